/* rtl/core/stl_pkg.sv */
package stl_pkg;

   localparam int MAX_PAYLOAD = 64;
   localparam int IDX_W       = $clog2(MAX_PAYLOAD);
   localparam int BYTE_W      = 8;
   localparam int SIZE_W      = 7;
   localparam int NUM_BANKS   = 2;
   localparam int BANK_W      = $clog2(NUM_BANKS);
   localparam int RAM_DEPTH   = NUM_BANKS * MAX_PAYLOAD;
   localparam int RAM_ADDR_W  = BANK_W + IDX_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [BYTE_W-1:0] SYNC_RESET = 8'd170;

   typedef struct packed {
      logic [BYTE_W-1:0] kind;
      logic [SIZE_W-1:0] size;
      logic [BANK_W-1:0] bank;
   } desc_type;

   typedef struct packed {
      logic                  en;
      logic [RAM_ADDR_W-1:0] addr;
      logic [BYTE_W-1:0]     data;
   } ram_wr_type;

   typedef struct packed {
      logic              valid;
      logic [BANK_W-1:0] bank;
   } drain_type;

endpackage

/* rtl/core/stl_ram.sv */
module stl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/stl_front.sv */
module stl_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [stl_pkg::BYTE_W-1:0]  sync_value,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [stl_pkg::BYTE_W-1:0]  req_rx_byte,
   input  logic                        q_full,
   input  stl_pkg::drain_type          drain,
   output stl_pkg::ram_wr_type         ram_wr,
   output logic                        desc_push,
   output stl_pkg::desc_type           desc
);
   import stl_pkg::*;

   typedef enum logic [1:0] {HUNT, KIND, SIZE, DATA} phase_type;

   phase_type              phase_ff, phase_in;
   logic [BYTE_W-1:0]      kind_ff, kind_in;
   logic [SIZE_W-1:0]      size_ff, size_in;
   logic [SIZE_W-1:0]      fill_ff, fill_in, fill_next;
   logic [BANK_W-1:0]      wbank_ff, wbank_in;
   logic [NUM_BANKS-1:0]   busy_ff, busy_in, busy_set, busy_clr;
   logic                   accept;

   assign req_full  = q_full || (phase_ff == DATA && busy_ff[wbank_ff]);
   assign accept    = req_push && !req_full;
   assign fill_next = fill_ff + 1'b1;

   always_comb begin
      phase_in    = phase_ff;
      kind_in     = kind_ff;
      size_in     = size_ff;
      fill_in     = fill_ff;
      wbank_in    = wbank_ff;
      busy_set    = '0;
      busy_clr    = '0;
      desc_push   = 1'b0;
      desc.kind   = kind_ff;
      desc.size   = size_ff;
      desc.bank   = wbank_ff;
      ram_wr.en   = 1'b0;
      ram_wr.addr = {wbank_ff, fill_ff[IDX_W-1:0]};
      ram_wr.data = req_rx_byte;
      if (accept) begin
         unique case (phase_ff)
            HUNT: begin
               if (req_rx_byte == sync_value) begin
                  phase_in = KIND;
                  fill_in  = '0;
               end
            end
            KIND: begin
               kind_in  = req_rx_byte;
               phase_in = SIZE;
            end
            SIZE: begin
               if (req_rx_byte == '0) begin
                  size_in   = '0;
                  desc.size = '0;
                  desc_push = 1'b1;
                  phase_in  = HUNT;
               end else if (req_rx_byte > BYTE_W'(MAX_PAYLOAD)) begin
                  phase_in = HUNT;
               end else begin
                  size_in  = req_rx_byte[SIZE_W-1:0];
                  fill_in  = '0;
                  phase_in = DATA;
               end
            end
            DATA: begin
               ram_wr.en = 1'b1;
               fill_in   = fill_next;
               if (fill_next == size_ff) begin
                  desc_push          = 1'b1;
                  busy_set[wbank_ff] = 1'b1;
                  wbank_in           = wbank_ff + 1'b1;
                  fill_in            = '0;
                  phase_in           = HUNT;
               end
            end
            default: phase_in = HUNT;
         endcase
      end
      busy_clr[drain.bank] = drain.valid;
      busy_in = (busy_ff & ~busy_clr) | busy_set;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= HUNT;
         kind_ff  <= '0;
         size_ff  <= '0;
         fill_ff  <= '0;
         wbank_ff <= '0;
         busy_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         size_ff  <= size_in;
         fill_ff  <= fill_in;
         wbank_ff <= wbank_in;
         busy_ff  <= busy_in;
      end
   end

   // a bank being drained is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      ram_wr.en |-> !busy_ff[wbank_ff])
      else $error("payload write into a bank still draining");

   assert property (@(posedge clock) disable iff (reset)
      desc_push |-> !q_full)
      else $error("descriptor pushed into full queue");

   assert property (@(posedge clock) disable iff (reset)
      drain.valid |-> busy_ff[drain.bank])
      else $error("drain done for a bank that was not busy");

endmodule

/* rtl/core/stl_desc_queue.sv */
module stl_desc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  stl_pkg::desc_type push_desc,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output stl_pkg::desc_type head
);
   import stl_pkg::*;

   desc_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
      else $error("descriptor queue count overflow");

endmodule

/* rtl/core/stl_back.sv */
module stl_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  stl_pkg::desc_type              q_head,
   output logic                           q_pop,
   output logic                           rd_en,
   output logic [stl_pkg::RAM_ADDR_W-1:0] rd_addr,
   input  logic [stl_pkg::BYTE_W-1:0]     rd_data,
   output stl_pkg::drain_type             drain,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [stl_pkg::BYTE_W-1:0]     rsp_frame_kind,
   output logic [stl_pkg::SIZE_W-1:0]     rsp_frame_size,
   output logic [stl_pkg::BYTE_W-1:0]     rsp_data_value,
   output logic                           rsp_has_data,
   output logic                           rsp_last
);
   import stl_pkg::*;

   typedef enum logic {B_IDLE, B_SEND} back_state_type;

   back_state_type      state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]   kind_ff, data_ff, data_in;
   logic [SIZE_W-1:0]   size_ff;
   logic                has_ff, has_in, last_ff, last_in;
   logic                out_free, load, is_last;

   assign out_free = !out_valid_ff || rsp_pop;
   assign is_last  = (SIZE_W'(idx_ff) + 1'b1) == q_head.size;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      q_pop       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = {q_head.bank, idx_ff};
      drain.valid = 1'b0;
      drain.bank  = q_head.bank;
      load        = 1'b0;
      data_in     = rd_data;
      has_in      = 1'b1;
      last_in     = is_last;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               if (q_head.size == '0) begin
                  if (out_free) begin
                     // empty frame
                     load    = 1'b1;
                     data_in = '0;
                     has_in  = 1'b0;
                     last_in = 1'b1;
                     q_pop   = 1'b1;
                  end
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = {q_head.bank, {IDX_W{1'b0}}};
                  idx_in   = '0;
                  state_in = B_SEND;
               end
            end
         end
         B_SEND: begin
            if (out_free) begin
               load = 1'b1;
               if (is_last) begin
                  q_pop       = 1'b1;
                  drain.valid = 1'b1;
                  state_in    = B_IDLE;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = {q_head.bank, idx_ff + 1'b1};
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= q_head.kind;
         size_ff <= q_head.size;
         data_ff <= data_in;
         has_ff  <= has_in;
         last_ff <= last_in;
      end
      if (reset) begin
         state_ff     <= B_IDLE;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_frame_kind = kind_ff;
   assign rsp_frame_size = size_ff;
   assign rsp_data_value = data_ff;
   assign rsp_has_data   = has_ff;
   assign rsp_last       = last_ff;

   // the frame being drained keeps its descriptor at the queue head
   assert property (@(posedge clock) disable iff (reset)
      state_ff == B_SEND |-> !q_empty && q_head.size != '0)
      else $error("drain running without a descriptor");

endmodule

/* rtl/core/sync_type_length_deframer.sv */
// result path: the first result of a frame reaches the rsp ports through the frame queue,
//   the first payload ram read and the output register (an empty frame skips the ram read)
// throughput: one input beat per cycle; one result beat per cycle within a frame while
//   the output is free, after a first payload read per nonempty frame; input stalls
//   while the payload bank to fill is still draining or the frame queue holds 2 frames
// reset: synchronous, clears parser, queue and drain control; payload ram is not cleared
module sync_type_length_deframer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [stl_pkg::BYTE_W-1:0]    req_rx_byte,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [stl_pkg::BYTE_W-1:0]    rsp_frame_kind,
   output logic [stl_pkg::SIZE_W-1:0]    rsp_frame_size,
   output logic [stl_pkg::BYTE_W-1:0]    rsp_data_value,
   output logic                          rsp_has_data,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [stl_pkg::BYTE_W-1:0]    csr_sync_value
);
   import stl_pkg::*;

   logic [BYTE_W-1:0]     sync_value_ff;
   ram_wr_type            ram_wr;
   desc_type              push_desc, q_head;
   drain_type             drain;
   logic                  desc_push, q_full, q_empty, q_pop;
   logic                  rd_en;
   logic [RAM_ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0]     rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_value_ff <= SYNC_RESET;
      end else if (csr_valid && csr_ready) begin
         sync_value_ff <= csr_sync_value;
      end
   end

   stl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .sync_value  (sync_value_ff),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .drain       (drain),
      .ram_wr      (ram_wr),
      .desc_push   (desc_push),
      .desc        (push_desc)
   );

   stl_desc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   stl_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   stl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .drain          (drain),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_frame_size (rsp_frame_size),
      .rsp_data_value (rsp_data_value),
      .rsp_has_data   (rsp_has_data),
      .rsp_last       (rsp_last)
   );

endmodule
